>>> rtl/circle_aabb_collision_unit_defines.svh
// Assertion macros shared by the circle/box collision RTL.
// Include by bare file name; no other dependencies.
`ifndef CIRCLE_AABB_COLLISION_UNIT_DEFINES_SVH
`define CIRCLE_AABB_COLLISION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("collision unit assertion failed");

// Next-cycle implication, disabled during reset.
`define CAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("collision unit assertion failed");

`endif

>>> rtl/cac_pkg.sv
// Package for the circle/box collision unit: stage counts, context struct
// and the one-step sqrt and divide helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cac_pkg;

    localparam int SQ_STAGES  = 16;  // two root bits per stage
    localparam int DIV_STAGES = 8;   // two quotient bits per stage

    typedef struct packed {
        logic        hit;
        logic        sx;
        logic        sy;
        logic [30:0] ax;
        logic [30:0] ay;
        logic [30:0] r;
    } t_ctx;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] q;
    } t_dv;

    function automatic t_sq sq_step(t_sq s, logic [1:0] pair);
        t_sq         o;
        logic [34:0] rm;
        logic [34:0] trial;
        rm    = {s.rem, pair};
        trial = {1'b0, s.root, 2'b01};
        if (rm >= trial) begin
            o.rem  = 33'(rm - trial);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = rm[32:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv dv_step(t_dv s, logic [30:0] d);
        t_dv         o;
        logic        ge;
        logic [31:0] diff;
        ge    = (s.rem >= {1'b0, d});
        diff  = ge ? (s.rem - {1'b0, d}) : s.rem;
        o.rem = {diff[30:0], 1'b0};
        o.q   = {s.q[14:0], ge};
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cac_front.sv
// Front stages: center offset, clamp to box, squares and radius compare.
// Depends on cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic signed [31:0] i_circle_x,
    input  wire logic signed [31:0] i_circle_y,
    input  wire logic        [30:0] i_circle_radius,
    input  wire logic signed [31:0] i_box_x,
    input  wire logic signed [31:0] i_box_y,
    input  wire logic        [30:0] i_half_width,
    input  wire logic        [30:0] i_half_height,
    output      logic               o_vld,
    output      logic        [63:0] o_num,
    output      cac_pkg::t_ctx      o_ctx
);
    import cac_pkg::*;

    // stage 1
    logic               r1_vld;
    logic signed [32:0] r1_dx, r1_dy;
    logic        [30:0] r1_hw, r1_hh, r1_r;
    // stage 2
    logic               r2_vld;
    logic               r2_far, r2_sx, r2_sy;
    logic        [30:0] r2_ax, r2_ay, r2_r;
    // stage 3
    logic               r3_vld;
    logic               r3_far, r3_sx, r3_sy;
    logic        [30:0] r3_ax, r3_ay, r3_r;
    logic        [61:0] r3_sqx, r3_sqy, r3_sqr;
    // stage 4
    logic               r4_vld;
    logic        [62:0] r4_sum;
    t_ctx               r4_ctx;

    logic signed [33:0] n_dx, n_dy, n_hw, n_hh;
    logic        [33:0] n_ax, n_ay;
    logic               n_sx, n_sy;
    logic        [62:0] n_sum;

    always_comb begin
        n_dx = {r1_dx[32], r1_dx};
        n_dy = {r1_dy[32], r1_dy};
        n_hw = {3'b000, r1_hw};
        n_hh = {3'b000, r1_hh};
        // offset from circle center to closest box point along each axis
        if (n_dx > n_hw) begin
            n_ax = $unsigned(n_dx - n_hw);
            n_sx = 1'b1;
        end else if (n_dx < -n_hw) begin
            n_ax = $unsigned(-n_hw - n_dx);
            n_sx = 1'b0;
        end else begin
            n_ax = '0;
            n_sx = 1'b0;
        end
        if (n_dy > n_hh) begin
            n_ay = $unsigned(n_dy - n_hh);
            n_sy = 1'b1;
        end else if (n_dy < -n_hh) begin
            n_ay = $unsigned(-n_hh - n_dy);
            n_sy = 1'b0;
        end else begin
            n_ay = '0;
            n_sy = 1'b0;
        end
        n_sum = {1'b0, r3_sqx} + {1'b0, r3_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= 33'(i_circle_x) - 33'(i_box_x);
            r1_dy  <= 33'(i_circle_y) - 33'(i_box_y);
            r1_hw  <= i_half_width;
            r1_hh  <= i_half_height;
            r1_r   <= i_circle_radius;

            // far when either axis alone exceeds the radius
            r2_far <= (n_ax > {3'b000, r1_r}) || (n_ay > {3'b000, r1_r});
            r2_sx  <= n_sx;
            r2_sy  <= n_sy;
            r2_ax  <= n_ax[30:0];
            r2_ay  <= n_ay[30:0];
            r2_r   <= r1_r;

            r3_far <= r2_far;
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_r   <= r2_r;
            r3_sqx <= r2_ax * r2_ax;
            r3_sqy <= r2_ay * r2_ay;
            r3_sqr <= r2_r * r2_r;

            r4_sum        <= n_sum;
            r4_ctx.hit    <= !r3_far && (n_sum <= {1'b0, r3_sqr});
            r4_ctx.sx     <= r3_sx;
            r4_ctx.sy     <= r3_sy;
            r4_ctx.ax     <= r3_ax;
            r4_ctx.ay     <= r3_ay;
            r4_ctx.r      <= r3_r;
        end
    end

    assign o_vld = r4_vld;
    assign o_num = {1'b0, r4_sum};
    assign o_ctx = r4_ctx;

endmodule

`default_nettype wire

>>> rtl/cac_sqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [63:0]   i_num,
    input  wire cac_pkg::t_ctx i_ctx,
    output      logic          o_vld,
    output      logic [30:0]   o_root,
    output      cac_pkg::t_ctx o_ctx
);
    import cac_pkg::*;

    logic [SQ_STAGES:0] w_vld;
    t_sq                w_st  [SQ_STAGES+1];
    logic [63:0]        w_num [SQ_STAGES+1];
    t_ctx               w_ctx [SQ_STAGES+1];

    assign w_vld[0] = i_vld;
    assign w_st[0]  = '0;
    assign w_num[0] = i_num;
    assign w_ctx[0] = i_ctx;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        t_sq         n_a, n_b;
        logic        r_vld;
        t_sq         r_st;
        logic [63:0] r_num;
        t_ctx        r_ctx;

        always_comb begin
            n_a = sq_step(w_st[g], w_num[g][63-4*g -: 2]);
            n_b = sq_step(n_a, w_num[g][61-4*g -: 2]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st  <= n_b;
                r_num <= w_num[g];
                r_ctx <= w_ctx[g];
            end
        end

        assign w_vld[g+1] = r_vld;
        assign w_st[g+1]  = r_st;
        assign w_num[g+1] = r_num;
        assign w_ctx[g+1] = r_ctx;
    end

    // root of a sum at most radius squared stays below 2^31
    assign o_vld  = w_vld[SQ_STAGES];
    assign o_root = w_st[SQ_STAGES].root[30:0];
    assign o_ctx  = w_ctx[SQ_STAGES];

endmodule

`default_nettype wire

>>> rtl/cac_div.sv
// Pipelined restoring divide of both axis offsets by the distance,
// two quotient bits per stage. Depends on cac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cac_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [30:0]   i_dist,
    input  wire cac_pkg::t_ctx i_ctx,
    output      logic          o_vld,
    output      logic [15:0]   o_qx,
    output      logic [15:0]   o_qy,
    output      logic [30:0]   o_dist,
    output      cac_pkg::t_ctx o_ctx
);
    import cac_pkg::*;

    logic [DIV_STAGES:0] w_vld;
    t_dv                 w_x    [DIV_STAGES+1];
    t_dv                 w_y    [DIV_STAGES+1];
    logic [30:0]         w_dist [DIV_STAGES+1];
    t_ctx                w_ctx  [DIV_STAGES+1];

    // offset never exceeds the distance, so the quotient fits 16 bits
    assign w_vld[0]  = i_vld;
    assign w_x[0]    = '{rem: {1'b0, i_ctx.ax}, q: '0};
    assign w_y[0]    = '{rem: {1'b0, i_ctx.ay}, q: '0};
    assign w_dist[0] = i_dist;
    assign w_ctx[0]  = i_ctx;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        t_dv         n_xa, n_xb, n_ya, n_yb;
        logic        r_vld;
        t_dv         r_x, r_y;
        logic [30:0] r_dist;
        t_ctx        r_ctx;

        always_comb begin
            n_xa = dv_step(w_x[g], w_dist[g]);
            n_xb = dv_step(n_xa, w_dist[g]);
            n_ya = dv_step(w_y[g], w_dist[g]);
            n_yb = dv_step(n_ya, w_dist[g]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_xb;
                r_y    <= n_yb;
                r_dist <= w_dist[g];
                r_ctx  <= w_ctx[g];
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_x[g+1]    = r_x;
        assign w_y[g+1]    = r_y;
        assign w_dist[g+1] = r_dist;
        assign w_ctx[g+1]  = r_ctx;
    end

    assign o_vld  = w_vld[DIV_STAGES];
    assign o_qx   = w_x[DIV_STAGES].q;
    assign o_qy   = w_y[DIV_STAGES].q;
    assign o_dist = w_dist[DIV_STAGES];
    assign o_ctx  = w_ctx[DIV_STAGES];

endmodule

`default_nettype wire

>>> rtl/circle_aabb_collision_unit.sv
// Circle versus axis-aligned box collision test, top level.
// Channels: one stream beat in carries a circle and a box in Q16.16; one
// stream beat out carries hit, unit normal (Q1.15) and depth (Q16.16).
// Pipeline: 4 front stages, 16 square-root stages, 8 divide stages and
// 1 output register between input beat and output valid.
// Throughput: one beat per cycle unless stalled; every stage is a register
// stage and the square root and divide are unrolled two bits per stage.
// Reset (synchronous, active low) clears every stage valid; data in flight
// is dropped and the output goes invalid.
// Receiver stall: while the output holds a beat that is not taken, the whole
// pipeline holds in place and s_axis tready drops; nothing is lost or
// repeated. A miss returns all zeros; a hit with zero distance returns a
// zero normal and depth equal to the radius.
// Depends on cac_pkg, cac_front, cac_sqrt, cac_div and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "circle_aabb_collision_unit_defines.svh"

module circle_aabb_collision_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output      logic         o_s_axis_tready,
    // circle_x, circle_y, circle_radius, box_x, box_y, half_width,
    // half_height, 3 zero pad bits
    input  wire logic [223:0] i_s_axis_tdata,
    output      logic         o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // hit, normal_x, normal_y, depth
    output      logic [63:0]  o_m_axis_tdata
);
    import cac_pkg::*;

    logic        w_en;
    logic        w_fr_vld, w_sq_vld, w_dv_vld;
    logic [63:0] w_num;
    t_ctx        w_fr_ctx, w_sq_ctx, w_dv_ctx;
    logic [30:0] w_root, w_dist;
    logic [15:0] w_qx, w_qy;

    logic        r_out_vld;
    logic [63:0] r_out_data;

    logic [15:0] n_nx, n_ny;
    logic [15:0] n_px, n_py;
    logic [63:0] n_out_data;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    cac_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_vld           (i_s_axis_tvalid),
        .i_circle_x      (i_s_axis_tdata[31:0]),
        .i_circle_y      (i_s_axis_tdata[63:32]),
        .i_circle_radius (i_s_axis_tdata[94:64]),
        .i_box_x         (i_s_axis_tdata[126:95]),
        .i_box_y         (i_s_axis_tdata[158:127]),
        .i_half_width    (i_s_axis_tdata[189:159]),
        .i_half_height   (i_s_axis_tdata[220:190]),
        .o_vld           (w_fr_vld),
        .o_num           (w_num),
        .o_ctx           (w_fr_ctx)
    );

    cac_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fr_vld),
        .i_num   (w_num),
        .i_ctx   (w_fr_ctx),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_ctx   (w_sq_ctx)
    );

    cac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_dist  (w_root),
        .i_ctx   (w_sq_ctx),
        .o_vld   (w_dv_vld),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_dist  (w_dist),
        .o_ctx   (w_dv_ctx)
    );

    always_comb begin
        // saturate a full +1.0 to the largest positive Q1.15 code
        n_px = w_qx[15] ? 16'h7FFF : w_qx;
        n_py = w_qy[15] ? 16'h7FFF : w_qy;
        n_nx = w_dv_ctx.sx ? 16'(-w_qx) : n_px;
        n_ny = w_dv_ctx.sy ? 16'(-w_qy) : n_py;
        if (w_dist == '0) begin
            n_nx = '0;
            n_ny = '0;
        end
        if (w_dv_ctx.hit) begin
            n_out_data = {w_dv_ctx.r - w_dist, n_ny, n_nx, 1'b1};
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    `CAC_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[63:1] == '0)
    `CAC_ASSERT_IMPL(a_ready_rule, i_clk, i_rst_n, 1'b1, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
    `CAC_ASSERT_NEXT(a_stall_sqrt, i_clk, i_rst_n, !w_en, $stable(w_sq_vld) && $stable(w_root))
    `CAC_ASSERT_NEXT(a_stall_div, i_clk, i_rst_n, !w_en, $stable(w_dv_vld) && $stable(w_qx))

endmodule

`default_nettype wire
